// ===== src/kvp_pkg.sv =====
// Shared types, constants and helpers of the key/value parameter tokenizer.
`default_nettype none

package kvp_pkg;

    localparam int ENTRY_LIMIT = 64;
    localparam int CNT_W       = $clog2(ENTRY_LIMIT + 1);
    localparam int OUT_CNT_W   = 7;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_KEY    = 3'd1,
        PH_VSTART = 3'd2,
        PH_PLAIN  = 3'd3,
        PH_QUOTE  = 3'd4,
        PH_ESC    = 3'd5,
        PH_HALT   = 3'd6
    } kvp_phase_t;

    typedef enum logic [1:0] {
        ROLE_NONE  = 2'd0,
        ROLE_KEY   = 2'd1,
        ROLE_VALUE = 2'd2
    } kvp_role_t;

    typedef enum logic [2:0] {
        ST_RUNNING    = 3'd0,
        ST_DONE       = 3'd1,
        ST_EMPTY_KEY  = 3'd2,
        ST_OPEN_QUOTE = 3'd3,
        ST_OPEN_ESC   = 3'd4,
        ST_TOO_MANY   = 3'd5
    } kvp_status_t;

    typedef struct packed {
        kvp_phase_t       phase;
        logic [CNT_W-1:0] count;
        kvp_status_t      err;
        logic             value_seen;
    } kvp_state_t;

    typedef struct packed {
        logic       string_end;
        logic [7:0] char_byte;
    } kvp_item_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] entry_count;
        kvp_status_t          status;
        logic                 final_res;
        logic                 entry_has_value;
        logic                 entry_closed;
        logic                 key_closed;
        kvp_role_t            byte_role;
        logic [7:0]           data_byte;
    } kvp_res_t;

    localparam kvp_state_t STATE_RESET = '{
        phase: PH_SKIP, count: '0, err: ST_RUNNING, value_seen: 1'b0
    };

    // Low bits of the entry count as reported on the result channel.
    function automatic logic [OUT_CNT_W-1:0] out_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OUT_CNT_W-1:0] wide;
        wide = {{OUT_CNT_W{1'b0}}, cnt};
        return wide[OUT_CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/key_value_parameter_tokenizer_top.sv =====
// Top level of the key/value parameter tokenizer: request registers and handshakes.
`default_nettype none

// Tokenizes a parameter line of space-separated key or key=value entries, one
// character per request, closed by a terminator request (s_tlast high, data
// ignored). Every request yields exactly one result request that tags the byte
// as key, value or neither, marks key and entry ends and reports the status and
// the running entry count; the terminator's result carries m_tlast and the final
// status, after which the parser returns to its reset state. Throughput is one
// request per clock cycle while the result channel does not stall. A request
// waits in the input register until the result register can take it, the result
// register and the parser state register being loaded at the same edge.
// Both sides stall independently: an input request is taken whenever the input
// register is empty or moves on into the result register in that cycle.

module key_value_parameter_tokenizer_top (
    input  wire        aclk,
    input  wire        aresetn,
    // Input channel
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [7:0]  s_tdata,   // [7:0] char_byte
    input  wire        s_tlast,   // string_end
    // Result channel
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [23:0] m_tdata,  // [7:0] data_byte, [8] key_closed,
                                  // [9] entry_closed, [10] entry_has_value,
                                  // [13:11] status, [20:14] entry_count,
                                  // [23:21] zero
    output logic [1:0] m_tuser,   // byte_role
    output logic       m_tlast    // final_res
);
    import kvp_pkg::*;

    logic       in_valid_reg;
    kvp_item_t  in_item_reg;
    logic       out_valid_reg;
    kvp_res_t   out_res_reg;
    kvp_state_t state_reg;
    kvp_state_t state_next;
    kvp_res_t   res_next;
    logic       advance;

    // The result register may take a new result when it is empty or drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    kvp_step u_step (
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.char_byte  <= s_tdata;
            in_item_reg.string_end <= s_tlast;
        end
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_res_reg.entry_count,
                       out_res_reg.status,
                       out_res_reg.entry_has_value,
                       out_res_reg.entry_closed,
                       out_res_reg.key_closed,
                       out_res_reg.data_byte};
    assign m_tuser  = out_res_reg.byte_role;
    assign m_tlast  = out_res_reg.final_res;

`ifndef SYNTHESIS
    // A terminator brings the parser back to its reset state.
    a_term_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.string_end) |=>
            (state_reg.phase == PH_SKIP && state_reg.count == '0
             && state_reg.err == ST_RUNNING))
        else $error("parser state not cleared after terminator");

    // A held error always goes with the halted phase.
    a_err_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.err != ST_RUNNING) |-> (state_reg.phase == PH_HALT))
        else $error("error held outside the halted phase");

    // The entry count never passes its limit.
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.count <= CNT_W'(ENTRY_LIMIT))
        else $error("entry count beyond limit");

    // An error result delivers no byte and closes no entry.
    a_err_masks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[13:11] != ST_RUNNING && m_tdata[13:11] != ST_DONE)
            |-> (m_tuser == ROLE_NONE && !m_tdata[9]))
        else $error("error result carries a byte or entry mark");
`endif

endmodule

`default_nettype wire

// ===== src/kvp_step.sv =====
// Next-state and result logic of the tokenizer for one character request.
`default_nettype none

module kvp_step (
    input  var kvp_pkg::kvp_state_t state_cur,
    input  var kvp_pkg::kvp_item_t  item,
    output kvp_pkg::kvp_state_t     state_next,
    output kvp_pkg::kvp_res_t       res
);
    import kvp_pkg::*;

    logic             full;
    logic [CNT_W-1:0] count_inc;
    kvp_state_t       st;
    logic [7:0]       data;
    kvp_role_t        role;
    logic             kclose;
    logic             eclose;
    logic             hasval;
    logic [7:0]       c;

    assign full      = (state_cur.count >= CNT_W'(ENTRY_LIMIT));
    assign count_inc = CNT_W'(state_cur.count + 1'b1);
    assign c         = item.char_byte;

    always_comb begin
        st     = state_cur;
        data   = 8'h00;
        role   = ROLE_NONE;
        kclose = 1'b0;
        eclose = 1'b0;
        hasval = 1'b0;

        if (item.string_end) begin
            unique case (state_cur.phase)
                PH_KEY, PH_VSTART, PH_PLAIN: begin
                    kclose = (state_cur.phase == PH_KEY);
                    if (full) begin
                        st.err   = ST_TOO_MANY;
                        st.phase = PH_HALT;
                    end else begin
                        st.count = count_inc;
                        eclose   = 1'b1;
                        hasval   = (state_cur.phase == PH_PLAIN);
                    end
                end
                PH_QUOTE: begin
                    st.err   = ST_OPEN_QUOTE;
                    st.phase = PH_HALT;
                end
                PH_ESC: begin
                    st.err   = ST_OPEN_ESC;
                    st.phase = PH_HALT;
                end
                default: begin
                end
            endcase
        end else begin
            unique case (state_cur.phase)
                PH_SKIP: begin
                    if (c == CH_EQUAL) begin
                        st.err   = ST_EMPTY_KEY;
                        st.phase = PH_HALT;
                    end else if (c != CH_SPACE) begin
                        data     = c;
                        role     = ROLE_KEY;
                        st.phase = PH_KEY;
                    end
                end
                PH_KEY: begin
                    if (c == CH_SPACE) begin
                        kclose = 1'b1;
                        if (full) begin
                            st.err   = ST_TOO_MANY;
                            st.phase = PH_HALT;
                        end else begin
                            st.count = count_inc;
                            eclose   = 1'b1;
                            st.phase = PH_SKIP;
                        end
                    end else if (c == CH_EQUAL) begin
                        kclose   = 1'b1;
                        st.phase = PH_VSTART;
                    end else begin
                        data = c;
                        role = ROLE_KEY;
                    end
                end
                PH_VSTART: begin
                    if (c == CH_QUOTE) begin
                        st.value_seen = 1'b0;
                        st.phase      = PH_QUOTE;
                    end else if (c == CH_SPACE) begin
                        if (full) begin
                            st.err   = ST_TOO_MANY;
                            st.phase = PH_HALT;
                        end else begin
                            st.count = count_inc;
                            eclose   = 1'b1;
                            st.phase = PH_SKIP;
                        end
                    end else begin
                        data     = c;
                        role     = ROLE_VALUE;
                        st.phase = PH_PLAIN;
                    end
                end
                PH_PLAIN: begin
                    if (c == CH_SPACE) begin
                        if (full) begin
                            st.err   = ST_TOO_MANY;
                            st.phase = PH_HALT;
                        end else begin
                            st.count = count_inc;
                            eclose   = 1'b1;
                            hasval   = 1'b1;
                            st.phase = PH_SKIP;
                        end
                    end else begin
                        data = c;
                        role = ROLE_VALUE;
                    end
                end
                PH_QUOTE: begin
                    if (c == CH_QUOTE) begin
                        st.value_seen = 1'b0;
                        if (full) begin
                            st.err   = ST_TOO_MANY;
                            st.phase = PH_HALT;
                        end else begin
                            st.count = count_inc;
                            eclose   = 1'b1;
                            hasval   = state_cur.value_seen;
                            st.phase = PH_SKIP;
                        end
                    end else if (c == CH_BSLASH) begin
                        st.value_seen = 1'b1;
                        st.phase      = PH_ESC;
                    end else begin
                        st.value_seen = 1'b1;
                        data          = c;
                        role          = ROLE_VALUE;
                    end
                end
                PH_ESC: begin
                    st.value_seen = 1'b1;
                    data          = c;
                    role          = ROLE_VALUE;
                    st.phase      = PH_QUOTE;
                end
                PH_HALT: begin
                end
                default: begin
                    st.err   = ST_EMPTY_KEY;
                    st.phase = PH_HALT;
                end
            endcase
        end

        // A held error masks every delivered byte and entry mark.
        res.key_closed  = kclose;
        res.final_res   = item.string_end;
        res.entry_count = out_count(st.count);
        if (st.err != ST_RUNNING) begin
            res.status          = st.err;
            res.data_byte       = 8'h00;
            res.byte_role       = ROLE_NONE;
            res.entry_closed    = 1'b0;
            res.entry_has_value = 1'b0;
        end else begin
            res.status          = item.string_end ? ST_DONE : ST_RUNNING;
            res.data_byte       = data;
            res.byte_role       = role;
            res.entry_closed    = eclose;
            res.entry_has_value = hasval;
        end

        state_next = item.string_end ? STATE_RESET : st;
    end

endmodule

`default_nettype wire

// ===== tb/sv/key_value_parameter_tokenizer_top_tb.sv =====
// Self-checking testbench of the key/value parameter tokenizer top level.
`default_nettype none

module key_value_parameter_tokenizer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kvp_pkg::*;

    // One character request, or a terminator request when term is set.
    typedef struct {
        logic [7:0] ch;
        logic       term;
    } char_req_t;

    // The tokenizer's verdict on one request, field by field.
    typedef struct {
        logic [7:0]  data_byte;
        kvp_role_t   role;
        logic        key_closed;
        logic        entry_closed;
        logic        has_value;
        kvp_status_t status;
        logic [6:0]  entry_count;
        logic        final_res;
    } token_t;

    localparam int TOTAL_CHARS = 930;  // rough size of the whole request stream
    localparam int DRAIN_AT    = 600;  // sender waits here until every result is back
    localparam int HOLD_AT     = 250;  // receiver pauses taking results after this one
    localparam int HOLD_CYCLES = 80;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [23:0] m_tdata;
    wire  [1:0]  m_tuser;
    wire         m_tlast;

    char_req_t pending_chars[$];
    token_t    expected_tokens[$];

    // Shadow of the parser state.
    kvp_phase_t  tok_phase = PH_SKIP;
    int          tok_entries = 0;
    kvp_status_t tok_err = ST_RUNNING;
    bit          tok_quoted_byte = 1'b0;

    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int send_gap = 0;
    int ready_gap = 0;
    int hold_left = 0;
    int n_taken_rx = 0;
    int final_status_seen[8];

    key_value_parameter_tokenizer_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic void tok_clear();
        tok_phase       = PH_SKIP;
        tok_entries     = 0;
        tok_err         = ST_RUNNING;
        tok_quoted_byte = 1'b0;
    endfunction

    function automatic void tok_halt(input kvp_status_t code);
        tok_err   = code;
        tok_phase = PH_HALT;
    endfunction

    // Counts a finished entry, unless the table is already full, in which
    // case the string is put into the too-many-entries error.
    function automatic bit tok_admit();
        if (tok_entries >= ENTRY_LIMIT) begin
            tok_halt(ST_TOO_MANY);
            return 1'b0;
        end
        tok_entries++;
        return 1'b1;
    endfunction

    function automatic token_t tokenize_byte(input logic [7:0] ch, input logic term);
        token_t t;
        bit     had;
        t.data_byte    = 8'h00;
        t.role         = ROLE_NONE;
        t.key_closed   = 1'b0;
        t.entry_closed = 1'b0;
        t.has_value    = 1'b0;
        t.status       = ST_RUNNING;
        t.final_res    = term;
        if (term) begin
            case (tok_phase)
                PH_KEY: begin
                    t.key_closed   = 1'b1;
                    t.entry_closed = tok_admit();
                end
                PH_VSTART: t.entry_closed = tok_admit();
                PH_PLAIN: begin
                    t.entry_closed = tok_admit();
                    t.has_value    = t.entry_closed;
                end
                PH_QUOTE: tok_halt(ST_OPEN_QUOTE);
                PH_ESC:   tok_halt(ST_OPEN_ESC);
                default: ;
            endcase
        end else begin
            case (tok_phase)
                PH_SKIP: begin
                    if (ch == CH_EQUAL) begin
                        tok_halt(ST_EMPTY_KEY);
                    end else if (ch != CH_SPACE) begin
                        t.data_byte = ch;
                        t.role      = ROLE_KEY;
                        tok_phase   = PH_KEY;
                    end
                end
                PH_KEY: begin
                    if (ch == CH_SPACE) begin
                        t.key_closed = 1'b1;
                        if (tok_admit()) begin
                            t.entry_closed = 1'b1;
                            tok_phase      = PH_SKIP;
                        end
                    end else if (ch == CH_EQUAL) begin
                        t.key_closed = 1'b1;
                        tok_phase    = PH_VSTART;
                    end else begin
                        t.data_byte = ch;
                        t.role      = ROLE_KEY;
                    end
                end
                PH_VSTART: begin
                    if (ch == CH_QUOTE) begin
                        tok_quoted_byte = 1'b0;
                        tok_phase       = PH_QUOTE;
                    end else if (ch == CH_SPACE) begin
                        if (tok_admit()) begin
                            t.entry_closed = 1'b1;
                            tok_phase      = PH_SKIP;
                        end
                    end else begin
                        t.data_byte = ch;
                        t.role      = ROLE_VALUE;
                        tok_phase   = PH_PLAIN;
                    end
                end
                PH_PLAIN: begin
                    if (ch == CH_SPACE) begin
                        if (tok_admit()) begin
                            t.entry_closed = 1'b1;
                            t.has_value    = 1'b1;
                            tok_phase      = PH_SKIP;
                        end
                    end else begin
                        t.data_byte = ch;
                        t.role      = ROLE_VALUE;
                    end
                end
                PH_QUOTE: begin
                    if (ch == CH_QUOTE) begin
                        had = tok_quoted_byte;
                        if (tok_admit()) begin
                            t.entry_closed = 1'b1;
                            t.has_value    = had;
                            tok_phase      = PH_SKIP;
                        end
                        tok_quoted_byte = 1'b0;
                    end else if (ch == CH_BSLASH) begin
                        // The backslash is dropped but already makes the value nonempty.
                        tok_quoted_byte = 1'b1;
                        tok_phase       = PH_ESC;
                    end else begin
                        tok_quoted_byte = 1'b1;
                        t.data_byte     = ch;
                        t.role          = ROLE_VALUE;
                    end
                end
                PH_ESC: begin
                    tok_quoted_byte = 1'b1;
                    t.data_byte     = ch;
                    t.role          = ROLE_VALUE;
                    tok_phase       = PH_QUOTE;
                end
                PH_HALT: ;
                default: tok_halt(ST_EMPTY_KEY);
            endcase
        end
        // A held error hides the byte and the entry marks, but not the key mark.
        if (tok_err != ST_RUNNING) begin
            t.status       = tok_err;
            t.data_byte    = 8'h00;
            t.role         = ROLE_NONE;
            t.entry_closed = 1'b0;
            t.has_value    = 1'b0;
        end else if (term) begin
            t.status = ST_DONE;
        end
        t.entry_count = tok_entries[6:0];
        if (term) tok_clear();
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    function automatic int draw_gap(input bit calm);
        if (calm) return 0;
        return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 17) : 0;
    endfunction

    task automatic put_byte(input logic [7:0] ch);
        char_req_t r;
        r.ch   = ch;
        r.term = 1'b0;
        pending_chars.push_back(r);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    // The character lane of a terminator is ignored, so it carries noise.
    task automatic put_end();
        char_req_t r;
        r.ch   = 8'($urandom_range(0, 255));
        r.term = 1'b1;
        pending_chars.push_back(r);
    endtask

    // Biased towards the bytes the parser treats specially.
    function automatic logic [7:0] pick_any();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_EQUAL;
            2:       return CH_QUOTE;
            3:       return CH_BSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly lower-case letters, now and then any byte the context allows.
    function automatic logic [7:0] pick_text(input bit no_equal, input bit quoted);
        logic [7:0] c;
        do begin
            if ($urandom_range(0, 9) < 7) c = 8'h61 + 8'($urandom_range(0, 25));
            else c = pick_any();
        end while (c == CH_SPACE || (no_equal && c == CH_EQUAL)
                   || (quoted && (c == CH_QUOTE || c == CH_BSLASH)));
        return c;
    endfunction

    task automatic put_key();
        int n;
        n = $urandom_range(1, 5);
        repeat (n) put_byte(pick_text(1'b1, 1'b0));
    endtask

    task automatic put_quoted_body();
        int n;
        n = $urandom_range(0, 5);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
                put_byte(CH_BSLASH);
                put_byte(pick_any());
            end else begin
                put_byte(pick_text(1'b0, 1'b1));
            end
        end
    endtask

    // One well-formed string, optionally spoilt near its end.
    task automatic put_random_string();
        int  entries;
        int  kind;
        int  n;
        bit  ended_quoted;
        entries = $urandom_range(0, 6);
        repeat ($urandom_range(0, 2)) put_byte(CH_SPACE);
        for (int i = 0; i < entries; i++) begin
            put_key();
            kind = $urandom_range(0, 3);
            ended_quoted = 1'b0;
            case (kind)
                0: ;
                1: put_byte(CH_EQUAL);
                2: begin
                    put_byte(CH_EQUAL);
                    n = $urandom_range(1, 5);
                    repeat (n) put_byte(pick_text(1'b0, 1'b0));
                end
                default: begin
                    put_byte(CH_EQUAL);
                    put_byte(CH_QUOTE);
                    put_quoted_body();
                    put_byte(CH_QUOTE);
                    ended_quoted = 1'b1;
                end
            endcase
            // A closing quote may run straight into the next key.
            if (i < entries - 1 && !(ended_quoted && $urandom_range(0, 1) != 0))
                repeat ($urandom_range(1, 2)) put_byte(CH_SPACE);
        end
        if ($urandom_range(0, 1) != 0) put_byte(CH_SPACE);
        case ($urandom_range(0, 9))
            0: begin
                put_byte(CH_SPACE);
                put_byte(CH_EQUAL);
                repeat ($urandom_range(0, 3)) put_byte(pick_any());
            end
            1: begin
                put_byte(CH_SPACE);
                put_key();
                put_byte(CH_EQUAL);
                put_byte(CH_QUOTE);
                put_quoted_body();
            end
            2: begin
                put_byte(CH_SPACE);
                put_key();
                put_byte(CH_EQUAL);
                put_byte(CH_QUOTE);
                put_quoted_body();
                put_byte(CH_BSLASH);
            end
            3: repeat ($urandom_range(1, 8)) put_byte(pick_any());
            default: ;
        endcase
        put_end();
    endtask

    // A string of n one-letter bare keys; the last one is closed either by the
    // terminator or by a space.
    task automatic put_many(input int n, input bit close_by_end);
        for (int i = 0; i < n; i++) begin
            put_byte(8'h61 + 8'($urandom_range(0, 25)));
            if (i < n - 1 || !close_by_end) put_byte(CH_SPACE);
        end
        put_end();
    endtask

    // ------------------------------------------------------------------
    // Driver: offers one request at a time from the pending queue
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
            send_gap = 0;
            tok_clear();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_tokens.push_back(tokenize_byte(s_tdata, s_tlast));
                n_accepted++;
                // A quiet stretch with no gaps in every third block of requests.
                send_gap = draw_gap(((n_accepted / 120) % 3) == 2);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() == 0
                             || (n_accepted == DRAIN_AT && expected_tokens.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_chars[0].ch;
                    s_tlast  <= pending_chars[0].term;
                    void'(pending_chars.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure, including one long hold-off
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            ready_gap = 0;
            hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_taken_rx++;
                ready_gap = draw_gap(((n_taken_rx / 90) % 3) == 0);
                if (n_taken_rx == HOLD_AT) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each result with the oldest prediction
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input int want, input int got);
        n_errors++;
        if (n_errors <= 10)
            $display("Mismatch in %s on result %0d: expected %0d, got %0d",
                     what, n_results, want, got);
    endtask

    task automatic check_token(input token_t want);
        if (m_tdata[7:0] !== want.data_byte)
            flag_mismatch("data_byte", want.data_byte, m_tdata[7:0]);
        if (m_tuser !== want.role)
            flag_mismatch("byte_role", want.role, m_tuser);
        if (m_tdata[8] !== want.key_closed)
            flag_mismatch("key_closed", want.key_closed, m_tdata[8]);
        if (m_tdata[9] !== want.entry_closed)
            flag_mismatch("entry_closed", want.entry_closed, m_tdata[9]);
        if (m_tdata[10] !== want.has_value)
            flag_mismatch("entry_has_value", want.has_value, m_tdata[10]);
        if (m_tdata[13:11] !== want.status)
            flag_mismatch("status", want.status, m_tdata[13:11]);
        if (m_tdata[20:14] !== want.entry_count)
            flag_mismatch("entry_count", want.entry_count, m_tdata[20:14]);
        if (m_tlast !== want.final_res)
            flag_mismatch("final_res", want.final_res, m_tlast);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_tokens.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("Result %0d arrived with no request outstanding", n_results);
            end else begin
                check_token(expected_tokens.pop_front());
            end
            if (m_tlast === 1'b1) final_status_seen[m_tdata[13:11]]++;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------

    initial begin
        foreach (final_status_seen[i]) final_status_seen[i] = 0;

        // Directed strings. Key 00h with a quoted value holding an escaped
        // quote, key FFh straight after the closing quote, then an empty
        // value cut short by the terminator.
        put_byte(8'h00);
        put_text("=\"\\\"\"");
        put_byte(8'hFF);
        put_byte(CH_EQUAL);
        put_end();
        // Empty value closed by a space, a quote used as a key, an empty
        // quoted value, an '=' right after the closing quote (empty key) and
        // a byte that arrives while the error is held.
        put_text("k= \"=\"\"=x");
        put_end();
        // Backslash as the last byte inside quotes.
        put_text("a=\"\\");
        put_end();
        // Quote left open at the terminator.
        put_text("b=\"");
        put_end();

        // Random part, with the entry-table limit exercised at and beyond it.
        put_many(ENTRY_LIMIT, 1'b1);
        while (pending_chars.size() < 300) put_random_string();
        put_many(ENTRY_LIMIT + 1, 1'b1);
        put_many(ENTRY_LIMIT + 2, 1'b0);
        while (pending_chars.size() < TOTAL_CHARS) put_random_string();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_chars.size() != 0 || s_tvalid || expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Checked %0d results from %0d requests over %0d strings.",
                 n_results, n_accepted, final_status_seen[ST_DONE]
                 + final_status_seen[ST_EMPTY_KEY] + final_status_seen[ST_OPEN_QUOTE]
                 + final_status_seen[ST_OPEN_ESC] + final_status_seen[ST_TOO_MANY]);
        $display("Strings ending clean %0d, empty key %0d, open quote %0d, ",
                 final_status_seen[ST_DONE], final_status_seen[ST_EMPTY_KEY],
                 final_status_seen[ST_OPEN_QUOTE],
                 "open escape %0d, table full %0d.",
                 final_status_seen[ST_OPEN_ESC], final_status_seen[ST_TOO_MANY]);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches in total", n_errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
